/* rtl/rde_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rde_pkg - radix digit emitter shared definitions
// Widths, types and constants used by the emitter and its divider.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 31;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int BASE_MIN    = 2;
    localparam int BASE_MAX    = 16;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int STEP_W = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [BASE_W-1:0]      base_t;
    typedef logic [DIGIT_W-1:0]     digit_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        digit_t remainder;
    } div_res_t;

endpackage : rde_pkg
`default_nettype wire

/* rtl/rde_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rde_divider - bit-serial restoring divider
// Divides a value by a small base, one quotient bit per cycle, and reports
// quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rde_divider
    import rde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire value_t   dividend,
    input  wire base_t    divisor,
    output div_res_t      res
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    value_t              quo_reg;
    digit_t              rem_reg;
    base_t               div_reg;

    logic [DIGIT_W:0]    rem_shift;
    logic                fits;
    logic [DIGIT_W:0]    rem_sub;
    digit_t              rem_next;

    assign rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits      = (rem_shift >= div_reg);
    assign rem_sub   = rem_shift - div_reg;
    assign rem_next  = fits ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(VALUE_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule : rde_divider
`default_nettype wire

/* rtl/radix_digit_emitter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit - integer to radix digit converter
// Converts a value to base 2..16 by repeated division and emits the digits
// most significant first, marking the least significant one with last.
// ----------------------------------------------------------------------------
// One word in gives one digit word out per digit of the value; a zero value
// or a base outside 2..16 gives none. Each digit is one pass of the shared
// bit-serial divider; once all digits are stacked, each is popped from the
// digit stack (pop state) and then shown (emit state) until taken. arg_stall
// stays high until the last digit has been taken.
module radix_digit_emitter_unit
    import rde_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   arg_valid,
    output logic        arg_stall,
    input  wire value_t value,
    input  wire base_t  base,
    output logic        dig_valid,
    input  wire logic   dig_stall,
    output digit_t      digit,
    output logic        last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    base_t             base_reg;
    digit_t            rd_data_reg;
    digit_t            stack_mem [MAX_DIGITS];

    logic              accept;
    logic              arg_ok;
    logic              div_start;
    value_t            div_value;
    base_t             div_base;
    div_res_t          div_res;
    logic              push;
    logic              pop;
    logic [CNT_W-1:0]  pop_cnt;

    assign arg_stall = (state_reg != ST_IDLE);
    assign accept    = arg_valid && !arg_stall;
    assign arg_ok    = (value != '0) && (base inside {[BASE_MIN:BASE_MAX]});
    assign pop_cnt   = count_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        div_start  = 1'b0;
        div_value  = div_res.quotient;
        div_base   = base_reg;
        push       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                div_value = value;
                div_base  = base;
                if (accept && arg_ok)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (count_reg < CNT_W'(MAX_DIGITS))
                    begin
                        push       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (div_res.quotient == '0)
                        state_next = ST_POP;
                    else
                        div_start = 1'b1;
                end
            end
            ST_POP:
            begin
                pop        = 1'b1;
                count_next = pop_cnt;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!dig_stall)
                    state_next = (count_reg == '0) ? ST_IDLE : ST_POP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            base_reg <= base;
    end

    // digit stack
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[count_reg[IDX_W-1:0]] <= div_res.remainder;
        if (pop)
            rd_data_reg <= stack_mem[pop_cnt[IDX_W-1:0]];
    end

    rde_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_value),
        .divisor  (div_base),
        .res      (div_res)
    );

    assign dig_valid = (state_reg == ST_EMIT);
    assign digit     = rd_data_reg;
    assign last      = (count_reg == '0);

endmodule : radix_digit_emitter_unit
`default_nettype wire

/* rtl/rde_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rde_checker - port-level checks for the radix digit emitter
// Watches both word channels of the top level and flags sequencing errors.
// ----------------------------------------------------------------------------
module rde_checker
    import rde_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   arg_valid,
    input wire logic   arg_stall,
    input wire value_t value,
    input wire base_t  base,
    input wire logic   dig_valid,
    input wire logic   dig_stall,
    input wire digit_t digit,
    input wire logic   last
);

    // stalled input word holds
    a_arg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (arg_valid && arg_stall) |=> (arg_valid && $stable(value) && $stable(base)))
        else $error("input word changed while stalled");

    // stalled digit word holds
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && dig_stall) |=> (dig_valid && $stable(digit) && $stable(last)))
        else $error("digit word changed while stalled");

    // no new input word while digits are pending
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> arg_stall)
        else $error("input taken while digits pending");

    // a pop, or idle after the last digit, follows every taken digit
    a_dig_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall) |=> !dig_valid)
        else $error("digit words back to back");

    // after the last digit the unit is free again
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && last) |=> !arg_stall)
        else $error("unit still busy after last digit");

endmodule : rde_checker

bind radix_digit_emitter_unit rde_checker u_rde_checker (.*);
`default_nettype wire

/* tb/radix_digit_emitter_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit_tb - self-checking bench for the radix emitter
// Sends value/base words, predicts the digit words by repeated division and
// checks every digit and last flag in order, with random gaps and stalls on
// both sides. Covers the value extremes, every base, a zero value and bases
// outside 2..16, then a few hundred random conversions of mixed length.
// ----------------------------------------------------------------------------
module radix_digit_emitter_unit_tb
    import rde_pkg::*;
;

    typedef struct {
        value_t val;
        base_t  radix;
    } conv_word_t;

    typedef struct {
        digit_t dval;
        logic   is_last;
    } digit_word_t;

    localparam int RANDOM_WORDS = 310;
    localparam int DRAIN_CYCLES = 1100;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   arg_valid = 1'b0;
    logic   arg_stall;
    value_t value     = '0;
    base_t  base      = '0;
    logic   dig_valid;
    logic   dig_stall = 1'b0;
    digit_t digit;
    logic   last;

    conv_word_t  pending_words[$];
    digit_word_t expected_digits[$];
    conv_word_t  next_word;
    digit_word_t exp_word;

    int unsigned hold_cnt    = 0;
    int unsigned stall_cnt   = 0;
    int unsigned stall_len   = 0;
    int unsigned words_sent  = 0;
    int unsigned words_quiet = 0;
    int unsigned digits_seen = 0;
    int unsigned errors      = 0;

    radix_digit_emitter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_stall (arg_stall),
        .value     (value),
        .base      (base),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .digit     (digit),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // repeated division, remainders stacked then popped msd first
    task automatic predict_digits(input value_t v, input base_t b);
        digit_t      stack[$];
        value_t      rest;
        digit_word_t dw;
        if (b < BASE_MIN || b > BASE_MAX || v == '0)
        begin
            words_quiet++;
            return;
        end
        rest = v;
        while (rest != '0)
        begin
            if (stack.size() < MAX_DIGITS)
                stack.push_back(digit_t'(rest % b));
            rest = rest / b;
        end
        for (int i = stack.size() - 1; i >= 0; i--)
        begin
            dw.dval    = stack[i];
            dw.is_last = (i == 0);
            expected_digits.push_back(dw);
        end
    endtask

    task automatic add_word(input value_t v, input base_t b);
        conv_word_t w;
        w.val   = v;
        w.radix = b;
        pending_words.push_back(w);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_valid <= 1'b0;
            value     <= '0;
            base      <= '0;
            hold_cnt  <= 0;
        end
        else
        begin
            if (arg_valid && !arg_stall)
            begin
                predict_digits(value, base);
                words_sent++;
            end
            if (!arg_valid || !arg_stall)
            begin
                if (hold_cnt != 0)
                begin
                    hold_cnt  <= hold_cnt - 1;
                    arg_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    arg_valid <= 1'b1;
                    value     <= next_word.val;
                    base      <= next_word.radix;
                    // back-to-back stretch
                    if (words_sent >= 150 && words_sent < 200)
                        hold_cnt <= 0;
                    else
                        hold_cnt <= idle_len();
                end
                else
                    arg_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (dig_valid && !dig_stall)
            begin
                digits_seen++;
                if (expected_digits.size() == 0)
                begin
                    $error("digit word with none expected: digit %0d last %0b", digit, last);
                    errors++;
                end
                else
                begin
                    exp_word = expected_digits.pop_front();
                    if (digit !== exp_word.dval)
                    begin
                        $error("digit: expected %0d, got %0d", exp_word.dval, digit);
                        errors++;
                    end
                    if (last !== exp_word.is_last)
                    begin
                        $error("last: expected %0b, got %0b", exp_word.is_last, last);
                        errors++;
                    end
                end
            end
            if (stall_cnt != 0)
            begin
                stall_cnt <= stall_cnt - 1;
                dig_stall <= 1'b1;
            end
            else
            begin
                if (digits_seen >= 1500 && digits_seen < 2200)
                    stall_len = 0;
                else
                    stall_len = idle_len();
                dig_stall <= (stall_len != 0);
                stall_cnt <= (stall_len > 1) ? stall_len - 1 : 0;
            end
        end
    end

    initial
    begin
        int unsigned real_words;
        int unsigned k;
        int unsigned r;
        logic [31:0] raw;
        base_t       b;

        // all ones, single digits, powers, base extremes and zero values
        add_word(value_t'(32'h7FFF_FFFF), base_t'(2));
        add_word(value_t'(32'h7FFF_FFFF), base_t'(16));
        add_word(value_t'(32'h4000_0000), base_t'(2));
        add_word(value_t'(1), base_t'(2));
        add_word(value_t'(15), base_t'(16));
        add_word(value_t'(16), base_t'(16));
        add_word(value_t'(1162261466), base_t'(3));
        add_word(value_t'(0), base_t'(10));
        add_word(value_t'(0), base_t'(2));
        // bases outside 2..16 are ignored
        add_word(value_t'(12345), base_t'(0));
        add_word(value_t'(12345), base_t'(1));
        add_word(value_t'(12345), base_t'(17));
        add_word(value_t'(32'h7FFF_FFFF), base_t'(31));
        for (int i = BASE_MIN; i <= BASE_MAX; i++)
            add_word(value_t'(32'h7FFF_FFFF - i * 977), base_t'(i));

        real_words = 0;
        while (real_words < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                add_word(value_t'(0), base_t'($urandom_range(BASE_MIN, BASE_MAX)));
            else if (r < 8)
            begin
                r = $urandom_range(0, 16);
                b = base_t'((r < 2) ? r : r + 15);
                add_word(value_t'($urandom), b);
            end
            else
            begin
                // mostly short values, some up to the full width
                if ($urandom_range(0, 4) == 0)
                    k = $urandom_range(17, VALUE_WIDTH);
                else
                    k = $urandom_range(1, 16);
                raw = ($urandom & ((32'h1 << k) - 32'h1)) | (32'h1 << (k - 1));
                add_word(value_t'(raw), base_t'($urandom_range(BASE_MIN, BASE_MAX)));
                real_words++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || arg_valid)
            @(posedge clk);
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d of them zero or with an unusable base",
                 words_sent, words_quiet);
        $display("%0d digit words checked across bases 2..16 with gaps and stalls",
                 digits_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout with %0d digit words outstanding", expected_digits.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : radix_digit_emitter_unit_tb
`default_nettype wire
